// ===== rtl/ssfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssfr_pkg
// Shared types and constants for the fixed-length speed frame receiver.
// ----------------------------------------------------------------------------
package ssfr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SPEED_W    = 16;
    localparam int unsigned NUM_SPEEDS = 4;
    localparam int unsigned BODY_COUNT = 8;
    localparam int unsigned BODY_IDX_W = 3;
    localparam int unsigned POS_W      = 4;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [POS_W-1:0] POS_BODY_FIRST = 4'd2;
    localparam logic [POS_W-1:0] POS_BODY_LAST  = 4'd9;
    localparam logic [POS_W-1:0] POS_TAIL       = 4'd11;

    localparam logic [BYTE_W-1:0] TYPE_BYTE_RESET = 8'h50;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TYPE   = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_TYPE   = 3'b010,
        PH_BODY   = 3'b100
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_byte;
        logic [BYTE_W-1:0] tail_byte;
        logic [BYTE_W-1:0] type_byte;
    } cfg_t;

    typedef struct packed {
        logic                      frame_ok;
        logic signed [SPEED_W-1:0] speed_one;
        logic signed [SPEED_W-1:0] speed_two;
        logic signed [SPEED_W-1:0] speed_three;
        logic signed [SPEED_W-1:0] speed_four;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/ssfr_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssfr_byte_if
// Valid/ready channel that carries one received serial byte per request.
// ----------------------------------------------------------------------------
interface ssfr_byte_if;
    logic                         valid;
    logic                         ready;
    logic [ssfr_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/ssfr_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssfr_result_if
// Valid/ready channel that carries one frame result per request.
// ----------------------------------------------------------------------------
interface ssfr_result_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 frame_ok;
    logic signed [ssfr_pkg::SPEED_W-1:0] speed_one;
    logic signed [ssfr_pkg::SPEED_W-1:0] speed_two;
    logic signed [ssfr_pkg::SPEED_W-1:0] speed_three;
    logic signed [ssfr_pkg::SPEED_W-1:0] speed_four;

    modport source (output valid, output frame_ok, output speed_one, output speed_two,
                    output speed_three, output speed_four, input ready);
    modport sink   (input valid, input frame_ok, input speed_one, input speed_two,
                    input speed_three, input speed_four, output ready);
endinterface
`default_nettype wire

// ===== rtl/ssfr_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssfr_parser
// Frame state machine, body byte store and held speeds. Produces the result
// of the closing byte in the same cycle that byte is taken.
// ----------------------------------------------------------------------------
module ssfr_parser
(
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          take,
    input  wire  [ssfr_pkg::BYTE_W-1:0]  rx_byte,
    input  ssfr_pkg::cfg_t               cfg,
    output logic                         res_valid,
    output ssfr_pkg::result_t            res
);

    ssfr_pkg::phase_t                 phase_reg, phase_next;
    logic [ssfr_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic [ssfr_pkg::BYTE_W-1:0]      body_reg [ssfr_pkg::BODY_COUNT];
    logic [ssfr_pkg::SPEED_W-1:0]     held_reg [ssfr_pkg::NUM_SPEEDS];
    logic [ssfr_pkg::SPEED_W-1:0]     held_next [ssfr_pkg::NUM_SPEEDS];
    logic                             body_we;
    logic [ssfr_pkg::BODY_IDX_W-1:0]  body_idx;
    logic                             closing;
    logic                             tail_ok;

    assign body_idx = ssfr_pkg::BODY_IDX_W'(pos_reg - ssfr_pkg::POS_BODY_FIRST);
    assign tail_ok  = (rx_byte == cfg.tail_byte);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        body_we    = 1'b0;
        closing    = 1'b0;
        unique case (phase_reg)
            ssfr_pkg::PH_TYPE:
            begin
                if (rx_byte == cfg.type_byte)
                begin
                    phase_next = ssfr_pkg::PH_BODY;
                    pos_next   = ssfr_pkg::POS_BODY_FIRST;
                end
                else
                begin
                    phase_next = ssfr_pkg::PH_HEADER;
                end
            end
            ssfr_pkg::PH_BODY:
            begin
                body_we = (pos_reg >= ssfr_pkg::POS_BODY_FIRST)
                       && (pos_reg <= ssfr_pkg::POS_BODY_LAST);
                if (pos_reg < ssfr_pkg::POS_TAIL)
                begin
                    pos_next = pos_reg + 1'b1;
                end
                else
                begin
                    closing    = 1'b1;
                    phase_next = ssfr_pkg::PH_HEADER;
                    pos_next   = '0;
                end
            end
            default:
            begin
                pos_next   = '0;
                phase_next = (rx_byte == cfg.header_byte) ? ssfr_pkg::PH_TYPE
                                                          : ssfr_pkg::PH_HEADER;
            end
        endcase
    end

    // Speeds are big-endian pairs of body bytes.
    always_comb
    begin
        for (int k = 0; k < ssfr_pkg::NUM_SPEEDS; k++)
        begin
            held_next[k] = held_reg[k];
            if (closing && tail_ok)
            begin
                held_next[k] = {body_reg[2*k], body_reg[2*k+1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ssfr_pkg::PH_HEADER;
            pos_reg   <= '0;
            for (int k = 0; k < ssfr_pkg::NUM_SPEEDS; k++)
            begin
                held_reg[k] <= '0;
            end
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            for (int k = 0; k < ssfr_pkg::NUM_SPEEDS; k++)
            begin
                held_reg[k] <= held_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && body_we)
        begin
            body_reg[body_idx] <= rx_byte;
        end
    end

    assign res_valid       = closing;
    assign res.frame_ok    = tail_ok;
    assign res.speed_one   = held_next[0];
    assign res.speed_two   = held_next[1];
    assign res.speed_three = held_next[2];
    assign res.speed_four  = held_next[3];

endmodule
`default_nettype wire

// ===== rtl/serial_speed_frame_receiver.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A result appears in the output register in the cycle after the closing byte is taken.
// Throughput: one byte per cycle; the input stalls only while a result waits unread.
// The frame state machine and output register set this timing.
// Reset clears the frame state, held speeds and output valid; type_byte resets to 0x50,
// header_byte and tail_byte to zero.
// ----------------------------------------------------------------------------
// serial_speed_frame_receiver
// Finds 12-byte speed frames in a serial byte stream and reports four speeds.
// ----------------------------------------------------------------------------
module serial_speed_frame_receiver
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire  [ssfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [ssfr_pkg::BYTE_W-1:0]      cfg_data,
    ssfr_byte_if.sink                        rx,
    ssfr_result_if.source                    result
);

    ssfr_pkg::cfg_t     cfg_reg;
    logic               take;
    logic               res_valid;
    ssfr_pkg::result_t  res;
    logic               out_valid_reg;
    ssfr_pkg::result_t  out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_byte <= '0;
            cfg_reg.tail_byte   <= '0;
            cfg_reg.type_byte   <= ssfr_pkg::TYPE_BYTE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ssfr_pkg::REG_HEADER: cfg_reg.header_byte <= cfg_data;
                ssfr_pkg::REG_TAIL:   cfg_reg.tail_byte   <= cfg_data;
                ssfr_pkg::REG_TYPE:   cfg_reg.type_byte   <= cfg_data;
                default:              cfg_reg             <= cfg_reg;
            endcase
        end
    end

    assign rx.ready = !out_valid_reg || result.ready;
    assign take     = rx.valid && rx.ready;

    ssfr_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .rx_byte   (rx.rx_byte),
        .cfg       (cfg_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.frame_ok    = out_reg.frame_ok;
    assign result.speed_one   = out_reg.speed_one;
    assign result.speed_two   = out_reg.speed_two;
    assign result.speed_three = out_reg.speed_three;
    assign result.speed_four  = out_reg.speed_four;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the speed frame receiver. A short table of frames
// with hand-worked results opens the run. Random traffic follows under several
// header, type and tail settings, with gaps on both channels in all runs but one.
// Its results are compared against a cycle-free parser model kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [ssfr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int unsigned IDLE_PCT   = 38;
    localparam int unsigned MAX_CYCLES = 300000;

    typedef struct packed {
        logic [ssfr_pkg::BYTE_W-1:0] rx_byte;
        logic                        typed;
        ssfr_pkg::result_t           want;
    } plan_row_t;

    localparam ssfr_pkg::result_t NO_RES = '0;
    localparam ssfr_pkg::result_t FIRST_FRAME =
        '{1'b1, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
    localparam ssfr_pkg::result_t TAIL_REJECT =
        '{1'b0, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};

    // Reset settings: header 0x00, type 0x50, tail 0x00.
    localparam plan_row_t DIRECTED [26] = '{
        // Accepted frame carrying the speed extremes.
        '{8'h00, 1'b0, NO_RES}, '{ssfr_pkg::TYPE_BYTE_RESET, 1'b0, NO_RES},
        '{8'h80, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h7F, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
        '{8'h12, 1'b0, NO_RES}, '{8'h00, 1'b1, FIRST_FRAME},
        // Bad tail: the speeds above are held.
        '{8'h00, 1'b0, NO_RES}, '{ssfr_pkg::TYPE_BYTE_RESET, 1'b0, NO_RES},
        '{8'h01, 1'b0, NO_RES}, '{8'h02, 1'b0, NO_RES},
        '{8'h03, 1'b0, NO_RES}, '{8'h04, 1'b0, NO_RES},
        '{8'h05, 1'b0, NO_RES}, '{8'h06, 1'b0, NO_RES},
        '{8'h07, 1'b0, NO_RES}, '{8'h08, 1'b0, NO_RES},
        '{8'hAA, 1'b0, NO_RES}, '{8'h01, 1'b1, TAIL_REJECT},
        // Header followed by a wrong type that equals the header value: it must
        // not start a new frame.
        '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}
    };

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [ssfr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ssfr_pkg::BYTE_W-1:0]    cfg_data;

    ssfr_byte_if   rx ();
    ssfr_result_if result ();

    serial_speed_frame_receiver uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx),
        .result    (result)
    );

    // Parser model state and the settings it works under.
    ssfr_pkg::cfg_t                      settings;
    ssfr_pkg::phase_t                    parse_at;
    logic [ssfr_pkg::POS_W-1:0]          slot;
    logic [ssfr_pkg::BYTE_W-1:0]         body_bytes [ssfr_pkg::BODY_COUNT];
    logic signed [ssfr_pkg::SPEED_W-1:0] held [ssfr_pkg::NUM_SPEEDS];

    ssfr_pkg::result_t frames_due [$];
    int unsigned       errors = 0;
    int unsigned       sent;
    int unsigned       cycles = 0;
    bit                gaps_on;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    task automatic parse_byte(input logic [ssfr_pkg::BYTE_W-1:0] b, output bit closed,
                              output ssfr_pkg::result_t r);
        logic [ssfr_pkg::SPEED_W-1:0] word;
        closed = 1'b0;
        r      = '0;
        case (parse_at)
            ssfr_pkg::PH_TYPE:
            begin
                if (b == settings.type_byte)
                begin
                    slot     = ssfr_pkg::POS_BODY_FIRST;
                    parse_at = ssfr_pkg::PH_BODY;
                end
                else
                begin
                    parse_at = ssfr_pkg::PH_HEADER;
                end
            end
            ssfr_pkg::PH_BODY:
            begin
                if (slot >= ssfr_pkg::POS_BODY_FIRST && slot <= ssfr_pkg::POS_BODY_LAST)
                    body_bytes[ssfr_pkg::BODY_IDX_W'(slot - ssfr_pkg::POS_BODY_FIRST)] = b;
                if (slot < ssfr_pkg::POS_TAIL)
                begin
                    slot = slot + 1'b1;
                end
                else
                begin
                    r.frame_ok = (b == settings.tail_byte);
                    if (r.frame_ok)
                    begin
                        for (int k = 0; k < ssfr_pkg::NUM_SPEEDS; k++)
                        begin
                            word    = {body_bytes[2*k], body_bytes[2*k+1]};
                            held[k] = word;
                        end
                    end
                    r.speed_one   = held[0];
                    r.speed_two   = held[1];
                    r.speed_three = held[2];
                    r.speed_four  = held[3];
                    parse_at = ssfr_pkg::PH_HEADER;
                    slot     = '0;
                    closed   = 1'b1;
                end
            end
            default:
            begin
                slot     = '0;
                parse_at = (b == settings.header_byte) ? ssfr_pkg::PH_TYPE
                                                       : ssfr_pkg::PH_HEADER;
            end
        endcase
    endtask

    // Offers one byte, waits for the request to be taken and records the
    // expected result. Valid is left high so back-to-back requests need no
    // second assignment in the same step.
    task automatic send_byte(input logic [ssfr_pkg::BYTE_W-1:0] b, input bit typed = 1'b0,
                             input ssfr_pkg::result_t want = '0);
        bit                closed;
        ssfr_pkg::result_t r;
        if (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            rx.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT)
                @(posedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx.ready);
        sent++;
        parse_byte(b, closed, r);
        if (closed)
            frames_due.push_back(typed ? want : r);
    endtask

    task automatic drain();
        rx.valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic load_settings(input logic [ssfr_pkg::BYTE_W-1:0] hdr,
                                 input logic [ssfr_pkg::BYTE_W-1:0] tl,
                                 input logic [ssfr_pkg::BYTE_W-1:0] ty);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= ssfr_pkg::REG_HEADER;
        cfg_data  <= hdr;
        @(posedge clk);
        cfg_index <= ssfr_pkg::REG_TAIL;
        cfg_data  <= tl;
        @(posedge clk);
        cfg_index <= ssfr_pkg::REG_TYPE;
        cfg_data  <= ty;
        @(posedge clk);
        // A write past the register list must change nothing.
        cfg_index <= REG_UNUSED;
        cfg_data  <= ssfr_pkg::BYTE_W'($urandom_range(255));
        @(posedge clk);
        cfg_we   <= 1'b0;
        settings = '{hdr, tl, ty};
    endtask

    function automatic logic [ssfr_pkg::BYTE_W-1:0] speed_byte();
        logic [ssfr_pkg::BYTE_W-1:0] corner [4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        if ($urandom_range(3) == 0)
            return corner[$urandom_range(3)];
        return ssfr_pkg::BYTE_W'($urandom_range(255));
    endfunction

    task automatic send_frame(input bit good_tail);
        send_byte(settings.header_byte);
        send_byte(settings.type_byte);
        for (int i = 0; i < ssfr_pkg::BODY_COUNT; i++)
            send_byte(speed_byte());
        send_byte(ssfr_pkg::BYTE_W'($urandom_range(255)));
        send_byte(good_tail ? settings.tail_byte
                            : settings.tail_byte ^ ssfr_pkg::BYTE_W'($urandom_range(1, 255)));
    endtask

    task automatic random_traffic(input int unsigned count);
        int unsigned stop;
        stop = sent + count;
        while (sent < stop)
        begin
            if ($urandom_range(99) < 75)
            begin
                send_frame($urandom_range(99) < 80);
            end
            else
            begin
                case ($urandom_range(2))
                    0: send_byte(ssfr_pkg::BYTE_W'($urandom_range(255)));
                    1:
                    begin
                        send_byte(settings.header_byte);
                        send_byte(settings.type_byte
                                  ^ ssfr_pkg::BYTE_W'($urandom_range(1, 255)));
                    end
                    default:
                    begin
                        // Cut-short frame: the next frame's bytes land in its body.
                        send_byte(settings.header_byte);
                        send_byte(settings.type_byte);
                        repeat ($urandom_range(1, 6))
                            send_byte(ssfr_pkg::BYTE_W'($urandom_range(255)));
                    end
                endcase
            end
        end
    endtask

    always @(posedge clk)
    begin
        ssfr_pkg::result_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (frames_due.size() == 0)
            begin
                report("unexpected result", result.frame_ok, 0);
            end
            else
            begin
                want = frames_due.pop_front();
                if (result.frame_ok !== want.frame_ok)
                    report("frame_ok", result.frame_ok, want.frame_ok);
                if (result.speed_one !== want.speed_one)
                    report("speed_one", result.speed_one, want.speed_one);
                if (result.speed_two !== want.speed_two)
                    report("speed_two", result.speed_two, want.speed_two);
                if (result.speed_three !== want.speed_three)
                    report("speed_three", result.speed_three, want.speed_three);
                if (result.speed_four !== want.speed_four)
                    report("speed_four", result.speed_four, want.speed_four);
            end
        end
        result.ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        rx.valid     <= 1'b0;
        rx.rx_byte   <= '0;
        sent     = 0;
        gaps_on  = 1'b1;
        settings = '{8'h00, 8'h00, ssfr_pkg::TYPE_BYTE_RESET};
        parse_at = ssfr_pkg::PH_HEADER;
        slot     = '0;
        for (int k = 0; k < ssfr_pkg::BODY_COUNT; k++)
            body_bytes[k] = '0;
        for (int k = 0; k < ssfr_pkg::NUM_SPEEDS; k++)
            held[k] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i].rx_byte, DIRECTED[i].typed, DIRECTED[i].want);
        random_traffic(120);

        // Extreme settings with both channels running flat out.
        load_settings(8'hFF, 8'hFF, 8'h00);
        gaps_on = 1'b0;
        random_traffic(140);
        gaps_on = 1'b1;

        load_settings(ssfr_pkg::BYTE_W'($urandom_range(255)),
                      ssfr_pkg::BYTE_W'($urandom_range(255)),
                      ssfr_pkg::BYTE_W'($urandom_range(255)));
        random_traffic(140);

        load_settings(8'h00, 8'hFF, 8'hFF);
        random_traffic(140);

        load_settings(ssfr_pkg::BYTE_W'($urandom_range(255)),
                      ssfr_pkg::BYTE_W'($urandom_range(255)),
                      ssfr_pkg::BYTE_W'($urandom_range(255)));
        random_traffic(140);

        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== serial_speed_frame_receiver.f =====
rtl/ssfr_pkg.sv
rtl/ssfr_byte_if.sv
rtl/ssfr_result_if.sv
rtl/ssfr_parser.sv
rtl/serial_speed_frame_receiver.sv
bench/tb_top.sv
